// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("asp assertion failed");
`define ASP_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("asp forbidden condition");
`else
`define ASP_ASSERT(label, clk, rst, prop)
`define ASP_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/asp_pkg.sv =====
// Types, constants and helpers for the shelf packer.
package asp_pkg;

   localparam int DefMaxPages = 8;

   localparam int GlyphW   = 11;
   localparam int EdgeW    = 12;
   localparam int PosW     = 12;
   localparam int PadW     = 3;
   localparam int PixW     = 10;
   localparam int PageW    = 3;
   localparam int StatusW  = 2;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = 10;

   localparam logic [StatusW-1:0] ST_PLACED  = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
   localparam logic [StatusW-1:0] ST_NO_ROOM = 2'd2;

   localparam logic [CsrIndexW-1:0] CSR_PIXEL_SIZE = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_PADDING    = 2'd1;

   localparam logic [PixW-1:0] PixelSizeReset = 10'd16;
   localparam logic [PadW-1:0] PaddingReset   = 3'd1;

   localparam logic [PixW-1:0]  SmallPixMax = 10'd24;
   localparam logic [PixW-1:0]  MidPixMax   = 10'd60;
   localparam logic [EdgeW-1:0] EdgeSmall   = 12'd512;
   localparam logic [EdgeW-1:0] EdgeMid     = 12'd1024;
   localparam logic [EdgeW-1:0] EdgeLarge   = 12'd2048;

   typedef logic [PageW-1:0] page_idx_type;

   // request word walking down the chain of page cells
   typedef struct packed {
      logic                valid;
      logic                done;
      logic [EdgeW-1:0]    pw;
      logic [EdgeW-1:0]    ph;
      logic [StatusW-1:0]  status;
      page_idx_type        page;
      logic [PosW-1:0]     pos_x;
      logic [PosW-1:0]     pos_y;
      logic                opened;
   } tok_type;

   function automatic logic [EdgeW-1:0] default_edge(input logic [PixW-1:0] px);
      logic [EdgeW-1:0] e;
      if (px <= SmallPixMax) begin
         e = EdgeSmall;
      end else if (px <= MidPixMax) begin
         e = EdgeMid;
      end else begin
         e = EdgeLarge;
      end
      return e;
   endfunction

endpackage

// ===== rtl/asp_cell.sv =====
// One page cell: holds a page's shelf state and tries the passing word on it.
`include "assert_macros.svh"
module asp_cell
   import asp_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [EdgeW-1:0] dflt_edge,
   input  logic [PadW-1:0]  pad,
   input  tok_type          tok_in,
   output tok_type          tok_out
);

   logic             open_ff, open_in;
   logic [EdgeW-1:0] ew_ff, ew_in, eh_ff, eh_in;
   logic [EdgeW-1:0] cx_ff, cx_in, cy_ff, cy_in, rh_ff, rh_in;
   tok_type          tok_out_ff, tok_out_in;

   logic [EdgeW:0]   x_end;
   logic             wrap;
   logic [EdgeW-1:0] row_x, row_h;
   logic [EdgeW:0]   row_y;
   logic [EdgeW+1:0] y_end;
   logic             fits, take;

   always_comb begin
      x_end = {1'b0, cx_ff} + {1'b0, tok_in.pw};
      wrap  = x_end > {1'b0, ew_ff};
      row_x = wrap ? '0 : cx_ff;
      row_h = wrap ? '0 : rh_ff;
      row_y = wrap ? ({1'b0, cy_ff} + {1'b0, rh_ff}) : {1'b0, cy_ff};
      y_end = {1'b0, row_y} + {2'b00, tok_in.ph};
      fits  = open_ff && (tok_in.pw <= ew_ff) && (tok_in.ph <= eh_ff) &&
              (y_end <= {2'b00, eh_ff});
      take  = tok_in.valid && !tok_in.done && (fits || !open_ff);

      open_in    = open_ff;
      ew_in      = ew_ff;
      eh_in      = eh_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rh_in      = rh_ff;
      tok_out_in = tok_in;

      if (take) begin
         tok_out_in.done   = 1'b1;
         tok_out_in.status = ST_PLACED;
         tok_out_in.page   = page_idx_type'(IDX);
         tok_out_in.opened = !open_ff;
         if (open_ff) begin
            cx_in = row_x + tok_in.pw;
            cy_in = row_y[EdgeW-1:0];
            rh_in = (row_h > tok_in.ph) ? row_h : tok_in.ph;
            tok_out_in.pos_x = row_x + PosW'(pad);
            tok_out_in.pos_y = row_y[EdgeW-1:0] + PosW'(pad);
         end else begin
            // fresh page, word lands at the top left corner
            open_in = 1'b1;
            ew_in   = (tok_in.pw > dflt_edge) ? tok_in.pw : dflt_edge;
            eh_in   = (tok_in.ph > dflt_edge) ? tok_in.ph : dflt_edge;
            cx_in   = tok_in.pw;
            cy_in   = '0;
            rh_in   = tok_in.ph;
            tok_out_in.pos_x = PosW'(pad);
            tok_out_in.pos_y = PosW'(pad);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         tok_out_ff <= '0;
      end else if (advance) begin
         open_ff    <= open_in;
         tok_out_ff <= tok_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ew_ff <= ew_in;
         eh_ff <= eh_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         rh_ff <= rh_in;
      end
   end

   assign tok_out = tok_out_ff;

   `ASP_ASSERT(a_open_sticks, clock, reset, open_ff |=> open_ff)
   `ASP_ASSERT(a_open_by_word, clock, reset,
      $rose(open_ff) |-> $past(tok_in.valid && !tok_in.done))
   `ASP_ASSERT(a_done_kept, clock, reset,
      (tok_in.valid && tok_in.done && advance) |=> (tok_out.valid && tok_out.done))

endmodule

// ===== rtl/atlas_shelf_packer_top.sv =====
// Top level of the shelf packer: entry stage, chain of page cells, result register.
//
// Each accepted word is padded and then walks a chain of MAX_PAGES page cells,
// one cell per cycle; the first open page with room takes it, or the first
// unopened cell opens a new page for it. One word is in flight at a time: the
// result is registered after the last cell, and req_ready returns in the same
// cycle as it appears, even if it then waits on rsp_ready, so a new word is
// taken only once the last one has left the end of the cell chain. A result
// still waiting when the next word reaches the end of the chain holds the
// chain until rsp_ready. csr_ready is always high; registers should only be
// written while no word is in flight.
`include "assert_macros.svh"
module atlas_shelf_packer_top
   import asp_pkg::*;
#(
   parameter int MAX_PAGES = DefMaxPages
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [GlyphW-1:0]    req_glyph_width,
   input  logic [GlyphW-1:0]    req_glyph_height,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [StatusW-1:0]   rsp_status,
   output logic [PageW-1:0]     rsp_page_index,
   output logic [PosW-1:0]      rsp_pos_x,
   output logic [PosW-1:0]      rsp_pos_y,
   output logic                 rsp_opened_page,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   logic [PixW-1:0]  pixel_size_ff;
   logic [PadW-1:0]  padding_ff;
   logic             busy_ff;
   tok_type          entry_ff, entry_in;
   tok_type          tok [MAX_PAGES+1];
   logic             advance;
   logic [EdgeW-1:0] dflt_edge;
   logic             rsp_valid_ff;
   tok_type          rsp_ff;
   logic             req_take;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign req_take  = req_valid && req_ready;
   assign dflt_edge = default_edge(pixel_size_ff);
   assign advance   = !(tok[MAX_PAGES].valid && rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_size_ff <= PixelSizeReset;
         padding_ff    <= PaddingReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_SIZE: pixel_size_ff <= csr_data[PixW-1:0];
            CSR_PADDING:    padding_ff    <= csr_data[PadW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      entry_in        = '0;
      entry_in.valid  = 1'b1;
      entry_in.pw     = EdgeW'(req_glyph_width) + EdgeW'({padding_ff, 1'b0});
      entry_in.ph     = EdgeW'(req_glyph_height) + EdgeW'({padding_ff, 1'b0});
      entry_in.status = ST_NO_ROOM;
      if (req_glyph_width == '0 || req_glyph_height == '0) begin
         entry_in.done   = 1'b1;
         entry_in.status = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            entry_ff <= entry_in;
         end else if (advance) begin
            entry_ff.valid <= 1'b0;
         end
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (tok[MAX_PAGES].valid && advance) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign tok[0] = entry_ff;

   for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
      asp_cell #(
         .IDX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .dflt_edge (dflt_edge),
         .pad       (padding_ff),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tok[MAX_PAGES].valid && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tok[MAX_PAGES].valid && advance) begin
         rsp_ff <= tok[MAX_PAGES];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_page_index  = rsp_ff.page;
   assign rsp_pos_x       = rsp_ff.pos_x;
   assign rsp_pos_y       = rsp_ff.pos_y;
   assign rsp_opened_page = rsp_ff.opened;

   `ASP_ASSERT(a_idle_chain_empty, clock, reset,
      !busy_ff |-> !tok[MAX_PAGES].valid && !entry_ff.valid)
   `ASP_ASSERT(a_miss_fields_zero, clock, reset,
      (rsp_valid && rsp_status != ST_PLACED) |-> (rsp_pos_x == '0 && rsp_opened_page == 1'b0))
   `ASP_NEVER(a_one_in_flight, clock, reset, busy_ff && req_ready)

endmodule

// ===== bench/asp_placement_checker.sv =====
// Shelf packer checker: predicts each placement and compares every result word.
module asp_placement_checker
   import asp_pkg::*;
#(
   parameter int MAX_PAGES = DefMaxPages
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [GlyphW-1:0]    req_glyph_width,
   input  logic [GlyphW-1:0]    req_glyph_height,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [StatusW-1:0]   rsp_status,
   input  logic [PageW-1:0]     rsp_page_index,
   input  logic [PosW-1:0]      rsp_pos_x,
   input  logic [PosW-1:0]      rsp_pos_y,
   input  logic                 rsp_opened_page,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   output int                   fail_count,
   output int                   placements_due
);

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [PageW-1:0]   page;
      logic [PosW-1:0]    x;
      logic [PosW-1:0]    y;
      logic               opened;
   } placement_type;

   placement_type   due_q[$];
   logic [PixW-1:0] pix_size;
   logic [PadW-1:0] pad;
   int              open_pages;
   int              pg_w[MAX_PAGES];
   int              pg_h[MAX_PAGES];
   int              row_x[MAX_PAGES];
   int              row_y[MAX_PAGES];
   int              row_h[MAX_PAGES];
   int              fails = 0;

   // commits the shelf cursor only when the padded glyph fits
   function automatic bit fit_on_page(input int p, input int pw, input int ph,
                                      output int x, output int y);
      int cx, cy, rh;
      x = 0;
      y = 0;
      if (pw > pg_w[p] || ph > pg_h[p]) return 1'b0;
      cx = row_x[p];
      cy = row_y[p];
      rh = row_h[p];
      if (cx + pw > pg_w[p]) begin
         cx = 0;
         cy = cy + rh;
         rh = 0;
      end
      if (cy + ph > pg_h[p]) return 1'b0;
      x = cx + int'(pad);
      y = cy + int'(pad);
      row_x[p] = (cx + pw) & 'hFFF;
      row_y[p] = cy & 'hFFF;
      row_h[p] = (rh > ph ? rh : ph) & 'hFFF;
      return 1'b1;
   endfunction

   function automatic placement_type place_glyph(input logic [GlyphW-1:0] w,
                                                 input logic [GlyphW-1:0] h);
      placement_type r;
      int pw, ph, x, y, dflt, p;
      bit done;
      r = '0;
      r.status = ST_NO_ROOM;
      done = 1'b0;
      if (w == 0 || h == 0) begin
         r.status = ST_EMPTY;
         return r;
      end
      pw = int'(w) + 2 * int'(pad);
      ph = int'(h) + 2 * int'(pad);
      for (p = 0; p < open_pages && !done; p++) begin
         if (fit_on_page(p, pw, ph, x, y)) begin
            done = 1'b1;
            r.status = ST_PLACED;
            r.page = PageW'(p);
            r.x = PosW'(x);
            r.y = PosW'(y);
         end
      end
      if (!done && open_pages < MAX_PAGES) begin
         p = open_pages;
         dflt = (pix_size <= SmallPixMax) ? int'(EdgeSmall) :
                (pix_size <= MidPixMax) ? int'(EdgeMid) : int'(EdgeLarge);
         pg_w[p] = pw > dflt ? pw : dflt;
         pg_h[p] = ph > dflt ? ph : dflt;
         row_x[p] = 0;
         row_y[p] = 0;
         row_h[p] = 0;
         open_pages = p + 1;
         if (fit_on_page(p, pw, ph, x, y)) begin
            r.status = ST_PLACED;
            r.page = PageW'(p);
            r.x = PosW'(x);
            r.y = PosW'(y);
            r.opened = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic [PosW-1:0] want,
                                     input logic [PosW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      placement_type want;
      if (reset) begin
         pix_size = PixelSizeReset;
         pad = PaddingReset;
         open_pages = 0;
         for (int p = 0; p < MAX_PAGES; p++) begin
            pg_w[p] = 0;
            pg_h[p] = 0;
            row_x[p] = 0;
            row_y[p] = 0;
            row_h[p] = 0;
         end
         due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PIXEL_SIZE: pix_size = csr_data[PixW-1:0];
               CSR_PADDING:    pad = csr_data[PadW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               fails++;
               $display("%0t: result word with none expected, status %0d page %0d x %0d y %0d",
                        $time, rsp_status, rsp_page_index, rsp_pos_x, rsp_pos_y);
            end else begin
               want = due_q.pop_front();
               fails += field_diff("status", PosW'(want.status), PosW'(rsp_status));
               fails += field_diff("page_index", PosW'(want.page), PosW'(rsp_page_index));
               fails += field_diff("pos_x", want.x, rsp_pos_x);
               fails += field_diff("pos_y", want.y, rsp_pos_y);
               fails += field_diff("opened_page", PosW'(want.opened),
                                   PosW'(rsp_opened_page));
            end
         end
         if (req_valid && req_ready)
            due_q.insert(due_q.size(), place_glyph(req_glyph_width, req_glyph_height));
      end
      fail_count <= fails;
      placements_due <= due_q.size();
   end

endmodule

// ===== bench/tb_atlas_shelf_packer_top.sv =====
// Testbench top for the shelf packer: stimulus, handshake pacing and verdict.
module tb_atlas_shelf_packer_top;
   import asp_pkg::*;

   localparam logic [CsrIndexW-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_SPARE_3 = 2'd3;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 175;
   localparam int DRAIN_SLACK = DefMaxPages + 12;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [GlyphW-1:0]    req_glyph_width;
   logic [GlyphW-1:0]    req_glyph_height;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [StatusW-1:0]   rsp_status;
   logic [PageW-1:0]     rsp_page_index;
   logic [PosW-1:0]      rsp_pos_x;
   logic [PosW-1:0]      rsp_pos_y;
   logic                 rsp_opened_page;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0]  csr_data;
   int                   fail_count;
   int                   placements_due;
   bit                   req_lazy;
   bit                   rsp_lazy;

   int pix_plan [PHASES] = '{0, 24, 25, 60, 61, 1023, 1, 512, 16};
   int pad_plan [PHASES] = '{0, 7, 3, 1, 5, 2, 7, 0, 4};

   atlas_shelf_packer_top #(.MAX_PAGES(DefMaxPages)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_index   (rsp_page_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_opened_page  (rsp_opened_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   asp_placement_checker #(.MAX_PAGES(DefMaxPages)) placement_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_index   (rsp_page_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_opened_page  (rsp_opened_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .placements_due   (placements_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAIL atlas_shelf_packer_top");
      $finish;
   end

   // result side: rsp_ready held low for a random per-word stall while lazy
   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = rsp_lazy ? $urandom_range(0, 9) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_glyph(input logic [GlyphW-1:0] w, input logic [GlyphW-1:0] h);
      int gap;
      gap = req_lazy ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_glyph_width = w;
      req_glyph_height = h;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CsrIndexW-1:0] idx,
                            input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_placements();
      @(negedge clock);
      req_valid = 1'b0;
      while (placements_due != 0) @(negedge clock);
   endtask

   // mostly small glyphs, some medium, a few full-range and empty ones
   task automatic pick_glyph(output logic [GlyphW-1:0] w, output logic [GlyphW-1:0] h);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         w = GlyphW'($urandom_range(0, 2047));
         h = GlyphW'($urandom_range(0, 2047));
         if ($urandom_range(0, 1) != 0) w = '0;
         else h = '0;
      end else if (r < 9) begin
         w = GlyphW'($urandom_range(1, 2047));
         h = GlyphW'($urandom_range(1, 2047));
      end else if (r < 20) begin
         w = GlyphW'($urandom_range(1, 400));
         h = GlyphW'($urandom_range(1, 400));
      end else begin
         w = GlyphW'($urandom_range(1, 48));
         h = GlyphW'($urandom_range(1, 48));
      end
   endtask

   initial begin : stimulus
      logic [GlyphW-1:0]   w, h;
      logic [CsrDataW-1:0] data;
      int                  drain_at;
      reset = 1'b1;
      req_valid = 1'b0;
      req_glyph_width = '0;
      req_glyph_height = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PIXEL_SIZE;
      csr_data = '0;
      req_lazy = 1'b1;
      rsp_lazy = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty glyphs, row wrap, forced page opens, oversized glyph
      send_glyph(0, 0);
      send_glyph(0, 7);
      send_glyph(9, 0);
      send_glyph(2047, 0);
      send_glyph(0, 2047);
      send_glyph(1, 1);
      send_glyph(1, 1);
      send_glyph(510, 1);
      send_glyph(511, 1);
      send_glyph(2047, 2047);
      send_glyph(1, 2);
      send_glyph(2, 1);

      for (int k = 0; k < PHASES; k++) begin
         drain_placements();
         write_csr(CSR_PIXEL_SIZE, CsrDataW'(pix_plan[k]));
         data = CsrDataW'($urandom);
         data[PadW-1:0] = PadW'(pad_plan[k]);
         write_csr(CSR_PADDING, data);
         write_csr($urandom_range(0, 1) != 0 ? CSR_SPARE_2 : CSR_SPARE_3,
                   CsrDataW'($urandom));
         drain_at = $urandom_range(20, PHASE_ITEMS - 20);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) begin
               req_lazy = $urandom_range(0, 2) != 0;
               rsp_lazy = $urandom_range(0, 2) != 0;
            end
            if (i == drain_at) drain_placements();
            pick_glyph(w, h);
            send_glyph(w, h);
         end
      end

      // pages are full by now: these run into the page limit
      send_glyph(2047, 2047);
      send_glyph(2047, 2047);
      send_glyph(1, 1);

      drain_placements();
      repeat (DRAIN_SLACK) @(negedge clock);
      if (fail_count == 0 && placements_due == 0) begin
         $display("PASS atlas_shelf_packer_top");
      end else begin
         $display("FAIL atlas_shelf_packer_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/asp_pkg.sv
rtl/asp_cell.sv
rtl/atlas_shelf_packer_top.sv
bench/asp_placement_checker.sv
bench/tb_atlas_shelf_packer_top.sv
